FILE: hw/rtl/dhcp_option_tlv_parser_defines.svh
// assertion macros for the dhcp options parser
// no dependencies; expects clk and rst in the scope of each use
`ifndef DHCP_OPTION_TLV_PARSER_DEFINES_SVH
`define DHCP_OPTION_TLV_PARSER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define DOPT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dopt check failed: same-cycle rule");

// next-cycle implication, checked while out of reset
`define DOPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dopt check failed: next-cycle rule");

`endif

FILE: hw/rtl/dopt_pkg.sv
// shared types and constants for the dhcp options parser
// no dependencies
package dopt_pkg;

  // walker phase codes
  localparam logic [2:0] PH_COOKIE  = 3'd0;
  localparam logic [2:0] PH_CODE    = 3'd1;
  localparam logic [2:0] PH_LEN     = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_IGNORE  = 3'd4;

  localparam logic [7:0] CODE_PAD = 8'h00;
  localparam logic [7:0] CODE_END = 8'hFF;
  localparam int         COOKIE_LEN = 4;

  // verdict codes
  localparam logic [2:0] V_PENDING  = 3'd0;
  localparam logic [2:0] V_SUCCESS  = 3'd1;
  localparam logic [2:0] V_BADMAGIC = 3'd2;
  localparam logic [2:0] V_TRUNC    = 3'd3;
  localparam logic [2:0] V_NOEND    = 3'd4;

  typedef struct packed {
    logic [7:0] option_code;
    logic [7:0] option_length;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [7:0] payload_index;
    logic       option_done;
    logic [2:0] verdict;
    logic       verdict_final;
  } res_t;

  // magic cookie 63 82 53 63
  function automatic logic [7:0] cookie_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h63;
      2'd1:    b = 8'h82;
      2'd2:    b = 8'h53;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/dhcp_option_tlv_parser.sv
// top level of the dhcp options parser: input register, walker, result register
// depends on dopt_pkg, dopt_in_stage, dopt_walker, dopt_out_stage and the defines header
//
//   channel | direction | handshake            | beat payload
//   in      | sink      | in_valid / in_ready   | data_byte, last_byte
//   out     | source    | out_valid / out_ready | option fields, verdict, verdict_final
//
// one beat per cycle unless out stalls; beats go through the input and result registers
// the walker state is updated in the cycle a beat moves from the input to the result register
// rst is synchronous; the parser rearms itself after each beat marked last_byte
// a stalled out channel holds one result and one input beat, then in_ready drops
`include "dhcp_option_tlv_parser_defines.svh"

module dhcp_option_tlv_parser
  import dopt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] option_code,
  output logic [7:0] option_length,
  output logic [7:0] payload_byte,
  output logic       payload_valid,
  output logic [7:0] payload_index,
  output logic       option_done,
  output logic [2:0] verdict,
  output logic       verdict_final
);

  logic       held_valid;
  logic [7:0] held_data;
  logic       held_last;
  logic       room;
  logic       advance;
  res_t       step_res;
  res_t       res_q;
  logic       pay_beat;
  logic       end_final;

  assign advance = held_valid && room;

  dopt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .take       (room),
    .held_valid (held_valid),
    .held_data  (held_data),
    .held_last  (held_last)
  );

  dopt_walker u_walk (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .data_byte (held_data),
    .last_byte (held_last),
    .res       (step_res)
  );

  dopt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (held_valid),
    .res_in    (step_res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign option_code   = res_q.option_code;
  assign option_length = res_q.option_length;
  assign payload_byte  = res_q.payload_byte;
  assign payload_valid = res_q.payload_valid;
  assign payload_index = res_q.payload_index;
  assign option_done   = res_q.option_done;
  assign verdict       = res_q.verdict;
  assign verdict_final = res_q.verdict_final;

  assign pay_beat  = out_valid && payload_valid;
  assign end_final = out_valid && verdict_final && option_done && option_code == CODE_END;

  `DOPT_ASSERT_NOW(a_payload_code, pay_beat, option_code != CODE_PAD && option_code != CODE_END)
  `DOPT_ASSERT_NOW(a_index_bound, pay_beat, payload_index < option_length)
  `DOPT_ASSERT_NOW(a_verdict_only_final, out_valid && !verdict_final, verdict == V_PENDING)
  `DOPT_ASSERT_NOW(a_end_success, end_final, verdict == V_SUCCESS)

endmodule

FILE: hw/rtl/dopt_in_stage.sv
// input register stage of the dhcp options parser
// depends on nothing but the handshake from the result register side
module dopt_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       take,
  output logic       held_valid,
  output logic [7:0] held_data,
  output logic       held_last
);

  // refill whenever empty or the held beat moves on this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= data_byte;
      held_last <= last_byte;
    end
  end

endmodule

FILE: hw/rtl/dopt_walker.sv
// option record walker: parse state and per-byte result logic
// depends on dopt_pkg
module dopt_walker
  import dopt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output res_t       res
);

  logic [2:0] phase, phase_next;
  logic [7:0] cur_code, cur_code_next;
  logic [7:0] cur_len, cur_len_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] byte_pos, byte_pos_next;
  logic [2:0] outcome, outcome_next;
  logic [1:0] idx;
  logic [7:0] left_dec;

  assign idx      = byte_pos[1:0];
  assign left_dec = bytes_left - 8'd1;

  always_comb begin
    phase_next      = phase;
    cur_code_next   = cur_code;
    cur_len_next    = cur_len;
    bytes_left_next = bytes_left;
    byte_pos_next   = byte_pos;
    outcome_next    = outcome;
    res             = '0;

    unique case (phase)
      PH_COOKIE: begin
        if (data_byte != cookie_byte(idx)) begin
          outcome_next = V_BADMAGIC;
          phase_next   = PH_IGNORE;
        end else if (idx == 2'(COOKIE_LEN - 1)) begin
          byte_pos_next = '0;
          phase_next    = PH_CODE;
        end else begin
          byte_pos_next = {6'd0, idx} + 8'd1;
        end
      end
      PH_CODE: begin
        res.option_code = data_byte;
        cur_code_next   = data_byte;
        cur_len_next    = '0;
        if (data_byte == CODE_PAD) begin
          res.option_done = 1'b1;
        end else if (data_byte == CODE_END) begin
          res.option_done = 1'b1;
          outcome_next    = V_SUCCESS;
          phase_next      = PH_IGNORE;
        end else begin
          phase_next = PH_LEN;
        end
      end
      PH_LEN: begin
        res.option_code   = cur_code;
        res.option_length = data_byte;
        cur_len_next      = data_byte;
        if (data_byte == 8'd0) begin
          res.option_done = 1'b1;
          phase_next      = PH_CODE;
        end else begin
          bytes_left_next = data_byte;
          byte_pos_next   = '0;
          phase_next      = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.option_code   = cur_code;
        res.option_length = cur_len;
        res.payload_byte  = data_byte;
        res.payload_valid = 1'b1;
        res.payload_index = byte_pos;
        byte_pos_next     = byte_pos + 8'd1;
        bytes_left_next   = left_dec;
        if (left_dec == 8'd0) begin
          res.option_done = 1'b1;
          phase_next      = PH_CODE;
        end
      end
      default: begin
        // ignore phase and unused codes: option fields stay zero; only the verdict can be set on a last byte
      end
    endcase

    if (last_byte) begin
      res.verdict_final = 1'b1;
      if (outcome_next != V_PENDING) begin
        res.verdict = outcome_next;
      end else if (phase_next == PH_COOKIE) begin
        res.verdict = V_BADMAGIC;
      end else if (phase_next == PH_LEN || phase_next == PH_PAYLOAD) begin
        res.verdict = V_TRUNC;
      end else begin
        res.verdict = V_NOEND;
      end
    end
  end

  // rearm on the final beat of an area
  always_ff @(posedge clk) begin
    if (rst || (advance && last_byte)) begin
      phase      <= PH_COOKIE;
      cur_code   <= '0;
      cur_len    <= '0;
      bytes_left <= '0;
      byte_pos   <= '0;
      outcome    <= V_PENDING;
    end else if (advance) begin
      phase      <= phase_next;
      cur_code   <= cur_code_next;
      cur_len    <= cur_len_next;
      bytes_left <= bytes_left_next;
      byte_pos   <= byte_pos_next;
      outcome    <= outcome_next;
    end
  end

endmodule

FILE: hw/rtl/dopt_out_stage.sv
// result register stage of the dhcp options parser
// depends on dopt_pkg
module dopt_out_stage
  import dopt_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  output logic room,
  output logic out_valid,
  input  logic out_ready,
  output res_t res_out
);

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && room) begin
      res_out <= res_in;
    end
  end

endmodule
